[design/ucer_pkg.sv]
// ----------------------------------------------------------------------------
// ucer_pkg: shared types and constants for the control endpoint responder
// Holds the word types, request codes, the sequencer states and the
// descriptor ROM contents.
// ----------------------------------------------------------------------------
package ucer_pkg;

    localparam int ROM_DEPTH_DEF = 256;
    localparam int ROM_USED      = 168;

    localparam logic [7:0] DIR_IN_BIT  = 8'h80;
    localparam logic [7:0] TYPE_FIELD  = 8'h60;
    localparam logic [7:0] TYPE_STD    = 8'h00;
    localparam logic [7:0] TYPE_CLASS  = 8'h20;

    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_SET_IDLE          = 8'h0A;

    localparam logic [7:0] DT_DEVICE = 8'd1;
    localparam logic [7:0] DT_CONFIG = 8'd2;
    localparam logic [7:0] DT_STRING = 8'd3;
    localparam logic [7:0] DT_REPORT = 8'h22;

    localparam logic [7:0] OFF_DEV  = 8'd0;
    localparam logic [7:0] LEN_DEV  = 8'd18;
    localparam logic [7:0] OFF_CFG  = 8'd18;
    localparam logic [7:0] LEN_CFG  = 8'd34;
    localparam logic [7:0] OFF_LANG = 8'd52;
    localparam logic [7:0] LEN_LANG = 8'd4;
    localparam logic [7:0] OFF_MANU = 8'd56;
    localparam logic [7:0] LEN_MANU = 8'd20;
    localparam logic [7:0] OFF_PROD = 8'd76;
    localparam logic [7:0] LEN_PROD = 8'd18;
    localparam logic [7:0] OFF_SER  = 8'd94;
    localparam logic [7:0] LEN_SER  = 8'd22;
    localparam logic [7:0] OFF_REP  = 8'd116;
    localparam logic [7:0] LEN_REP  = 8'd52;

    localparam logic [6:0] MPS_RESET = 7'd16;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ZLP    = 2'd1,
        KIND_ADDR   = 2'd2,
        KIND_CONFIG = 2'd3
    } kind_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } in_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic       last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_ACTION,
        ST_PACKET,
        ST_SEND,
        ST_WAIT
    } state_t;

    function automatic logic [7:0] rom_data(input logic [7:0] a);
        logic [7:0] d;
        case (a)
            8'd0: d = 8'd18;   8'd1: d = 8'h01;  8'd2: d = 8'h10;  8'd3: d = 8'h01;
            8'd4: d = 8'h00;   8'd5: d = 8'h00;  8'd6: d = 8'h00;  8'd7: d = 8'h10;
            8'd8: d = 8'h88;   8'd9: d = 8'h88;  8'd10: d = 8'h01; 8'd11: d = 8'h00;
            8'd12: d = 8'h00;  8'd13: d = 8'h01; 8'd14: d = 8'h01; 8'd15: d = 8'h02;
            8'd16: d = 8'h03;  8'd17: d = 8'h01;
            8'd18: d = 8'h09;  8'd19: d = 8'h02; 8'd20: d = 8'd34; 8'd21: d = 8'h00;
            8'd22: d = 8'h01;  8'd23: d = 8'h01; 8'd24: d = 8'h00; 8'd25: d = 8'h80;
            8'd26: d = 8'h32;
            8'd27: d = 8'h09;  8'd28: d = 8'h04; 8'd29: d = 8'h00; 8'd30: d = 8'h00;
            8'd31: d = 8'h01;  8'd32: d = 8'h03; 8'd33: d = 8'h01; 8'd34: d = 8'h02;
            8'd35: d = 8'h00;
            8'd36: d = 8'h09;  8'd37: d = 8'h21; 8'd38: d = 8'h10; 8'd39: d = 8'h01;
            8'd40: d = 8'h21;  8'd41: d = 8'h01; 8'd42: d = 8'h22; 8'd43: d = 8'd52;
            8'd44: d = 8'h00;
            8'd45: d = 8'h07;  8'd46: d = 8'h05; 8'd47: d = 8'h81; 8'd48: d = 8'h03;
            8'd49: d = 8'h10;  8'd50: d = 8'h00; 8'd51: d = 8'h0A;
            8'd52: d = 8'h04;  8'd53: d = 8'h03; 8'd54: d = 8'h09; 8'd55: d = 8'h04;
            8'd56: d = 8'd20;  8'd57: d = 8'h03; 8'd58: d = 8'h41; 8'd60: d = 8'h76;
            8'd62: d = 8'h65;  8'd64: d = 8'h72; 8'd66: d = 8'h4D; 8'd68: d = 8'h65;
            8'd70: d = 8'h64;  8'd72: d = 8'h69; 8'd74: d = 8'h61;
            8'd76: d = 8'd18;  8'd77: d = 8'h03; 8'd78: d = 8'h55; 8'd80: d = 8'h73;
            8'd82: d = 8'h62;  8'd84: d = 8'h4D; 8'd86: d = 8'h6F; 8'd88: d = 8'h75;
            8'd90: d = 8'h73;  8'd92: d = 8'h65;
            8'd94: d = 8'd22;  8'd95: d = 8'h03; 8'd96: d = 8'h32; 8'd98: d = 8'h30;
            8'd100: d = 8'h31; 8'd102: d = 8'h36; 8'd104: d = 8'h2F; 8'd106: d = 8'h30;
            8'd108: d = 8'h34; 8'd110: d = 8'h2F; 8'd112: d = 8'h32; 8'd114: d = 8'h31;
            8'd116: d = 8'h05; 8'd117: d = 8'h01; 8'd118: d = 8'h09; 8'd119: d = 8'h02;
            8'd120: d = 8'ha1; 8'd121: d = 8'h01; 8'd122: d = 8'h09; 8'd123: d = 8'h01;
            8'd124: d = 8'ha1; 8'd125: d = 8'h00; 8'd126: d = 8'h05; 8'd127: d = 8'h09;
            8'd128: d = 8'h19; 8'd129: d = 8'h01; 8'd130: d = 8'h29; 8'd131: d = 8'h03;
            8'd132: d = 8'h15; 8'd133: d = 8'h00; 8'd134: d = 8'h25; 8'd135: d = 8'h01;
            8'd136: d = 8'h95; 8'd137: d = 8'h03; 8'd138: d = 8'h75; 8'd139: d = 8'h01;
            8'd140: d = 8'h81; 8'd141: d = 8'h02; 8'd142: d = 8'h95; 8'd143: d = 8'h01;
            8'd144: d = 8'h75; 8'd145: d = 8'h05; 8'd146: d = 8'h81; 8'd147: d = 8'h03;
            8'd148: d = 8'h05; 8'd149: d = 8'h01; 8'd150: d = 8'h09; 8'd151: d = 8'h30;
            8'd152: d = 8'h09; 8'd153: d = 8'h31; 8'd154: d = 8'h09; 8'd155: d = 8'h38;
            8'd156: d = 8'h15; 8'd157: d = 8'h81; 8'd158: d = 8'h25; 8'd159: d = 8'h7f;
            8'd160: d = 8'h75; 8'd161: d = 8'h08; 8'd162: d = 8'h95; 8'd163: d = 8'h03;
            8'd164: d = 8'h81; 8'd165: d = 8'h06; 8'd166: d = 8'hc0; 8'd167: d = 8'hc0;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

endpackage

[design/ucer_rom.sv]
// ----------------------------------------------------------------------------
// ucer_rom: descriptor ROM
// Registered read of the fixed descriptor bytes; addresses past the stored
// bytes or past the ROM depth read as zero.
// ----------------------------------------------------------------------------
module ucer_rom #(
    parameter int ROM_DEPTH = ucer_pkg::ROM_DEPTH_DEF
) (
    input  logic       clk,
    input  logic [7:0] addr,
    output logic [7:0] data
);
    import ucer_pkg::*;

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if ({24'd0, addr} < ROM_DEPTH)
            data_reg <= rom_data(addr);
        else
            data_reg <= 8'h00;
    end

    assign data = data_reg;

endmodule

[design/usb_control_endpoint_responder.sv]
// A packet of n descriptor bytes leaves one byte per cycle (ROM port limited) while
// the output is not stalled; a descriptor length check in ST_MOD may come first,
// and no item is taken until the last word goes.
// Reset (rst_n, asynchronous, low): packet size 16, pointer, count and
// zero-length flag cleared, sequencer idle.
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder: endpoint zero control responder
// Decodes setup words and IN completions and streams descriptor bytes.
// ----------------------------------------------------------------------------
module usb_control_endpoint_responder #(
    parameter int ROM_DEPTH = ucer_pkg::ROM_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [6:0]           cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ucer_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ucer_pkg::out_word_t  out_data
);
    import ucer_pkg::*;

    state_t     state_reg, state_next;
    logic [6:0] mps_reg;
    logic [7:0] ptr_reg, ptr_next;
    logic [7:0] rem_reg, rem_next;
    logic       zlp_reg, zlp_next;
    logic [7:0] len_reg, len_next;      // descriptor length under test
    logic [7:0] cnt_reg, cnt_next;      // bytes left in this packet
    logic [7:0] addr_reg, addr_next;    // ROM read address
    logic [1:0] akind_reg, akind_next;
    logic [7:0] aval_reg, aval_next;
    out_word_t  obuf_reg, obuf_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] rom_q;
    logic [6:0] mps_eff;

    // Clamp the packet size into 8..64
    always_comb
    begin
        if (mps_reg < 7'd8)
            mps_eff = 7'd8;
        else if (mps_reg > 7'd64)
            mps_eff = 7'd64;
        else
            mps_eff = mps_reg;
    end

    // Present the next address so the ROM word lines up with addr_reg
    ucer_rom #(.ROM_DEPTH(ROM_DEPTH)) u_rom (
        .clk  (clk),
        .addr (addr_next),
        .data (rom_q)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mps_reg    <= MPS_RESET;
            ptr_reg    <= 8'd0;
            rem_reg    <= 8'd0;
            zlp_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            rem_reg    <= rem_next;
            zlp_reg    <= zlp_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
                mps_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        cnt_reg   <= cnt_next;
        addr_reg  <= addr_next;
        akind_reg <= akind_next;
        aval_reg  <= aval_next;
        obuf_reg  <= obuf_next;
    end

    always_comb
    begin
        logic [7:0] rtype;
        logic [7:0] code;
        logic [7:0] dtype;
        logic [7:0] start;
        logic [7:0] dlen;
        logic       known;
        logic       fits;
        logic       obuf_free;
        rtype      = in_data.request_type;
        code       = in_data.request_code;
        dtype      = in_data.request_value[15:8];
        start      = ptr_reg;
        dlen       = 8'd0;
        known      = 1'b1;
        fits       = 1'b0;
        obuf_free  = !ovalid_reg || out_ready;
        state_next = state_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        zlp_next   = zlp_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        akind_next = akind_reg;
        aval_next  = aval_reg;
        obuf_next  = obuf_reg;
        ovalid_next = ovalid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    akind_next = KIND_DATA;
                    state_next = ST_PACKET;
                    if (!in_data.mode)
                    begin
                        zlp_next   = 1'b0;
                        state_next = ST_IDLE;
                        if ((rtype & DIR_IN_BIT) != 8'd0)
                        begin
                            if ((rtype & TYPE_FIELD) == TYPE_STD
                                && code == REQ_GET_DESCRIPTOR)
                            begin
                                case (dtype)
                                    DT_DEVICE: begin start = OFF_DEV; dlen = LEN_DEV; end
                                    DT_CONFIG: begin start = OFF_CFG; dlen = LEN_CFG; end
                                    DT_REPORT: begin start = OFF_REP; dlen = LEN_REP; end
                                    DT_STRING:
                                    begin
                                        case (in_data.request_value[7:0])
                                            8'd0: begin start = OFF_LANG; dlen = LEN_LANG; end
                                            8'd1: begin start = OFF_MANU; dlen = LEN_MANU; end
                                            8'd2: begin start = OFF_PROD; dlen = LEN_PROD; end
                                            8'd3: begin start = OFF_SER;  dlen = LEN_SER;  end
                                            default:
                                            begin
                                                // unknown string: empty reply
                                                start    = ptr_reg;
                                                dlen     = 8'd0;
                                                zlp_next = 1'b1;
                                            end
                                        endcase
                                    end
                                    default: known = 1'b0;
                                endcase
                                if (known)
                                begin
                                    ptr_next = start;
                                    fits = in_data.request_length > {8'd0, dlen};
                                    if (fits)
                                    begin
                                        rem_next   = dlen;
                                        len_next   = dlen;
                                        state_next = ST_MOD;
                                    end
                                    else
                                    begin
                                        rem_next   = in_data.request_length[7:0];
                                        state_next = ST_PACKET;
                                    end
                                end
                            end
                        end
                        else if ((rtype & TYPE_FIELD) == TYPE_STD
                                 && (code == REQ_SET_ADDRESS
                                     || code == REQ_SET_CONFIGURATION))
                        begin
                            akind_next = (code == REQ_SET_ADDRESS) ? KIND_ADDR : KIND_CONFIG;
                            aval_next  = in_data.request_value[7:0];
                            rem_next   = 8'd0;
                            zlp_next   = 1'b1;
                            state_next = ST_ACTION;
                        end
                        else if ((rtype & TYPE_FIELD) == TYPE_CLASS
                                 && code == REQ_SET_IDLE)
                        begin
                            rem_next   = 8'd0;
                            zlp_next   = 1'b1;
                            state_next = ST_PACKET;
                        end
                    end
                end
            end

            ST_MOD:
            begin
                // repeated subtraction: len mod packet size
                if (len_reg >= {1'b0, mps_eff})
                    len_next = len_reg - {1'b0, mps_eff};
                else
                begin
                    if (len_reg == 8'd0)
                        zlp_next = 1'b1;
                    state_next = ST_PACKET;
                end
            end

            ST_ACTION:
            begin
                if (obuf_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next.kind    = akind_reg;
                    obuf_next.payload = aval_reg;
                    obuf_next.last    = 1'b0;
                    state_next = ST_PACKET;
                end
            end

            ST_PACKET:
            begin
                if (rem_reg == 8'd0)
                begin
                    if (zlp_reg)
                    begin
                        if (obuf_free)
                        begin
                            zlp_next = 1'b0;
                            ovalid_next = 1'b1;
                            obuf_next.kind    = KIND_ZLP;
                            obuf_next.payload = 8'd0;
                            obuf_next.last    = 1'b1;
                            state_next = ST_WAIT;
                        end
                    end
                    else if (akind_reg != KIND_DATA)
                    begin
                        // action word already out; mark is missing only if no zlp
                        state_next = ST_WAIT;
                    end
                    else
                        state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next  = (rem_reg > {1'b0, mps_eff}) ? {1'b0, mps_eff} : rem_reg;
                    rem_next  = rem_reg - cnt_next;
                    addr_next = ptr_reg;
                    if (rem_next != 8'd0)
                        ptr_next = ptr_reg + cnt_next;
                    state_next = ST_SEND;
                end
            end

            ST_SEND:
            begin
                // ROM data for addr_reg is present now
                if (obuf_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next.kind    = KIND_DATA;
                    obuf_next.payload = rom_q;
                    obuf_next.last    = (cnt_reg == 8'd1);
                    cnt_next  = cnt_reg - 8'd1;
                    addr_next = addr_reg + 8'd1;
                    if (cnt_reg == 8'd1)
                        state_next = ST_WAIT;
                end
            end

            ST_WAIT:
            begin
                if (!ovalid_reg || out_ready)
                    state_next = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result word dropped under stall");
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_WAIT && state_reg == ST_IDLE) |-> !out_valid)
        else $error("idle with result pending");
    a_mps_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mps_eff >= 7'd8 && mps_eff <= 7'd64))
        else $error("packet size clamp failed");
`endif

endmodule

[sim/usb_control_endpoint_responder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder_test: regression bench for the EP0 responder
// Drives setup and IN-complete words with random valid gaps and output stalls,
// predicts every result word from a behavioural copy of the endpoint and
// checks each accepted result word in order against that prediction.
// ----------------------------------------------------------------------------
module usb_control_endpoint_responder_test;
    import ucer_pkg::*;

    // Scoreboard: holds a behavioural copy of the endpoint state and the queue
    // of result words still owed by the block.
    class ep0_scoreboard;
        logic [6:0]  packet_size;
        logic [7:0]  rd_ptr;
        logic [7:0]  remaining;
        logic        zlp_armed;
        out_word_t   owed[$];
        int          errors;

        function void reset_state();
            packet_size = MPS_RESET;
            rd_ptr = 8'd0;
            remaining = 8'd0;
            zlp_armed = 1'b0;
            owed.delete();
            errors = 0;
        endfunction

        function int clamp_mps();
            if (packet_size < 7'd8)
                return 8;
            if (packet_size > 7'd64)
                return 64;
            return int'(packet_size);
        endfunction

        // Own copy of the descriptor image, built the same way the ROM is laid out.
        function logic [7:0] descriptor_byte(int addr);
            logic [7:0] image [0:167];
            int         k;
            image = '{
                18, 1, 8'h10, 8'h01, 0, 0, 0, 8'h10, 8'h88, 8'h88, 8'h01, 0, 0, 8'h01,
                1, 2, 3, 1,
                8'h09, 8'h02, 34, 0, 1, 1, 0, 8'h80, 8'h32,
                8'h09, 8'h04, 0, 0, 1, 3, 1, 2, 0,
                8'h09, 8'h21, 8'h10, 1, 8'h21, 1, 8'h22, 52, 0,
                8'h07, 8'h05, 8'h81, 3, 8'h10, 0, 8'h0A,
                4, 3, 9, 4,
                20, 3, "A", 0, "v", 0, "e", 0, "r", 0, "M", 0, "e", 0, "d", 0, "i", 0,
                "a", 0,
                18, 3, "U", 0, "s", 0, "b", 0, "M", 0, "o", 0, "u", 0, "s", 0, "e", 0,
                22, 3, "2", 0, "0", 0, "1", 0, "6", 0, "/", 0, "0", 0, "4", 0, "/", 0,
                "2", 0, "1", 0,
                8'h05, 8'h01, 8'h09, 8'h02, 8'ha1, 8'h01, 8'h09, 8'h01, 8'ha1, 8'h00,
                8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h03, 8'h15, 8'h00, 8'h25, 8'h01,
                8'h95, 8'h03, 8'h75, 8'h01, 8'h81, 8'h02, 8'h95, 8'h01, 8'h75, 8'h05,
                8'h81, 8'h03, 8'h05, 8'h01, 8'h09, 8'h30, 8'h09, 8'h31, 8'h09, 8'h38,
                8'h15, 8'h81, 8'h25, 8'h7f, 8'h75, 8'h08, 8'h95, 8'h03, 8'h81, 8'h06,
                8'hc0, 8'hc0};
            k = addr;
            if (k < ROM_USED)
                return image[k];
            return 8'h00;
        endfunction

        function void owe(kind_t k, logic [7:0] p);
            out_word_t w;
            w.kind = k;
            w.payload = p;
            w.last = 1'b0;
            owed.push_back(w);
        endfunction

        // One packet: up to a max-size run of bytes, or the armed zero-length packet.
        function void emit_packet();
            int cnt;
            int mps;
            mps = clamp_mps();
            if (remaining > mps)
                cnt = mps;
            else if (remaining != 0)
                cnt = remaining;
            else
            begin
                if (zlp_armed)
                begin
                    zlp_armed = 1'b0;
                    owe(KIND_ZLP, 8'h00);
                end
                return;
            end
            for (int i = 0; i < cnt; i++)
                owe(KIND_DATA, descriptor_byte((rd_ptr + i) & 8'hFF));
            remaining = remaining - cnt;
            if (remaining != 0)
                rd_ptr = rd_ptr + cnt;
        endfunction

        function void descriptor_request(logic [15:0] value, logic [15:0] wlen);
            int start;
            int len;
            case (value[15:8])
                DT_DEVICE: begin start = OFF_DEV; len = LEN_DEV; end
                DT_CONFIG: begin start = OFF_CFG; len = LEN_CFG; end
                DT_REPORT: begin start = OFF_REP; len = LEN_REP; end
                DT_STRING:
                begin
                    case (value[7:0])
                        8'd0: begin start = OFF_LANG; len = LEN_LANG; end
                        8'd1: begin start = OFF_MANU; len = LEN_MANU; end
                        8'd2: begin start = OFF_PROD; len = LEN_PROD; end
                        8'd3: begin start = OFF_SER;  len = LEN_SER;  end
                        default:
                        begin
                            // unknown string index: empty reply, pointer kept
                            start = rd_ptr;
                            len = 0;
                            zlp_armed = 1'b1;
                        end
                    endcase
                end
                default: return;
            endcase
            if (wlen > len)
            begin
                if (len % clamp_mps() == 0)
                    zlp_armed = 1'b1;
            end
            else
                len = wlen;
            rd_ptr = start;
            remaining = len;
            emit_packet();
        endfunction

        // Note an accepted input word and queue the result words it causes.
        function void note_input(in_word_t w);
            int first;
            first = owed.size();
            if (w.mode)
                emit_packet();
            else
            begin
                zlp_armed = 1'b0;
                if (w.request_type & DIR_IN_BIT)
                begin
                    if ((w.request_type & TYPE_FIELD) == TYPE_STD &&
                        w.request_code == REQ_GET_DESCRIPTOR)
                        descriptor_request(w.request_value, w.request_length);
                end
                else if ((w.request_type & TYPE_FIELD) == TYPE_STD &&
                         (w.request_code == REQ_SET_ADDRESS ||
                          w.request_code == REQ_SET_CONFIGURATION))
                begin
                    owe(w.request_code == REQ_SET_ADDRESS ? KIND_ADDR : KIND_CONFIG,
                        w.request_value[7:0]);
                    remaining = 8'd0;
                    zlp_armed = 1'b1;
                    emit_packet();
                end
                else if ((w.request_type & TYPE_FIELD) == TYPE_CLASS &&
                         w.request_code == REQ_SET_IDLE)
                begin
                    remaining = 8'd0;
                    zlp_armed = 1'b1;
                    emit_packet();
                end
            end
            if (owed.size() > first)
                owed[owed.size() - 1].last = 1'b1;
        endfunction

        // Check one accepted result word against the oldest owed word.
        function void check_result(out_word_t got, realtime t);
            out_word_t exp_w;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result word %h", t, got);
                errors++;
                return;
            end
            exp_w = owed.pop_front();
            if (got.kind !== exp_w.kind || got.payload !== exp_w.payload ||
                got.last !== exp_w.last)
            begin
                $display("%0t: result mismatch expected kind %0d payload %h last %b, got kind %0d payload %h last %b",
                         t, exp_w.kind, exp_w.payload, exp_w.last,
                         got.kind, got.payload, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_word_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_word_t  out_data;
    bit         calm = 1'b0;   // final stretch: no idling on either side

    ep0_scoreboard board;

    always #6 clk = ~clk;

    usb_control_endpoint_responder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Sink: check on every accepted word, then pick the next ready in bursts.
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data, $realtime);
        if (calm)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= (stall_left == 0);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one word, hold it until accepted, then at times drop valid for a gap.
    task automatic send_word(in_word_t w);
        int gap;
        in_data <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(w);
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic setup_word(logic [7:0] rt, logic [7:0] rc, logic [15:0] val,
                              logic [15:0] len);
        in_word_t w;
        w.mode = 1'b0;
        w.request_type = rt;
        w.request_code = rc;
        w.request_value = val;
        w.request_length = len;
        send_word(w);
    endtask

    task automatic in_done();
        in_word_t w;
        w = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
        w.mode = 1'b1;
        send_word(w);
    endtask

    // Drop valid at once, wait until every owed word has arrived, then let the
    // block settle so a word with no result cannot still be in flight.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_mps(logic [6:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.packet_size = v;
    endtask

    // Well-formed enumeration-like traffic with random content, plus noise.
    task automatic random_word();
        int         pick;
        logic [15:0] val;
        logic [15:0] len;
        logic [7:0]  dtype [4];
        dtype = '{DT_DEVICE, DT_CONFIG, DT_STRING, DT_REPORT};
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
        if (pick < 45)
        begin
            val = {dtype[$urandom_range(0, 3)], 8'($urandom_range(0, 5))};
            if ($urandom_range(0, 9) == 0)
                val = 16'($urandom);
            setup_word(DIR_IN_BIT | 8'($urandom_range(0, 31)), REQ_GET_DESCRIPTOR, val, len);
        end
        else if (pick < 75)
            in_done();
        else if (pick < 82)
            setup_word(8'($urandom_range(0, 31)),
                       $urandom_range(0, 1) ? REQ_SET_ADDRESS : REQ_SET_CONFIGURATION,
                       16'($urandom), 16'($urandom));
        else if (pick < 87)
            setup_word(TYPE_CLASS | 8'($urandom_range(0, 31)), REQ_SET_IDLE,
                       16'($urandom), 16'($urandom));
        else
        begin
            in_word_t w;
            w = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
            send_word(w);
        end
    endtask

    initial
    begin
        logic [6:0] sizes [6];
        board = new();
        board.reset_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every descriptor, caps, zero-length cases, actions, noise.
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'd0}, 16'hFFFF);
        in_done();
        in_done();
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'd0}, 16'd9);
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'd0}, 16'd255);
        in_done();
        in_done();
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd0}, 16'd64);
        in_done();
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd1}, 16'd20);
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd2}, 16'd0);
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd3}, 16'd100);
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, {DT_STRING, 8'hFF}, 16'd0);
        in_done();
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, {DT_REPORT, 8'd0}, 16'd52);
        in_done();
        in_done();
        in_done();
        setup_word(8'h00, REQ_SET_ADDRESS, 16'hFF7F, 16'hFFFF);
        setup_word(8'h00, REQ_SET_CONFIGURATION, 16'h0001, 16'd0);
        setup_word(TYPE_CLASS | 8'h01, REQ_SET_IDLE, 16'h0000, 16'd0);
        setup_word(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        setup_word(DIR_IN_BIT, REQ_GET_DESCRIPTOR, 16'h0500, 16'd8);
        in_done();
        drain();

        // Random phases over packet sizes, extremes and out-of-range values too.
        sizes = '{7'd8, 7'd64, 7'd32, 7'd0, 7'd127, 7'd16};
        foreach (sizes[s])
        begin
            write_mps(sizes[s]);
            if (s == 5)
                calm = 1'b1;
            repeat (49) random_word();
            drain();
        end

        if (board.errors == 0)
            $display("usb_control_endpoint_responder regression: pass");
        else
            $display("usb_control_endpoint_responder regression: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("usb_control_endpoint_responder regression: fail");
        $finish;
    end
endmodule
